@@ sv/mrf_pkg.sv @@
// Package for the Modbus RTU response framer.
// Shared types, codes and the bytewise CRC-16/MODBUS update; no dependencies.
`default_nettype none

package mrf_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  SLAVE_ADDR_RESET = 8'h01;
  localparam logic [7:0]  FC_EXC_BIT_MASK  = 8'h80;
  localparam logic [7:0]  FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0]  FC_WRITE_SINGLE  = 8'h06;
  localparam logic [8:0]  LEN_EXCEPTION    = 9'd5;
  localparam logic [8:0]  LEN_READ_EXTRA   = 9'd5;
  localparam logic [8:0]  LEN_WRITE_ECHO   = 9'd8;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL    = 16'hA001;

  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_GOOD     = 2'd1,
    ST_BAD      = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FC_EXCEPTION,
    FC_READ,
    FC_WRITE,
    FC_OTHER
  } fc_class_t;

  // Classified input item as it sits in the queue.
  typedef struct packed {
    logic      is_arm;
    logic      addr_hit;
    fc_class_t fc_class;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/mrf_ifs.sv @@
// Channel interfaces for the Modbus RTU response framer.
// Valid/ready request and frame-byte channels; no package dependency.
`default_nettype none

interface mrf_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface mrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [8:0] byte_index;
  logic       frame_last;
  logic [1:0] frame_status;

  modport source (output valid, output frame_byte, output byte_index, output frame_last,
                  output frame_status, input ready);
  modport sink   (input valid, input frame_byte, input byte_index, input frame_last,
                  input frame_status, output ready);
endinterface

`default_nettype wire

@@ sv/modbus_response_framer_top.sv @@
// Top level of the Modbus RTU response framer.
// Instantiates mrf_front and mrf_back; depends on mrf_pkg and mrf_ifs.
//
//   channel  dir  handshake          payload
//   in_if    in   valid/ready        mode[0], rx_byte[7:0]
//   out_if   out  valid/ready        frame_byte[7:0], byte_index[8:0],
//                                    frame_last, frame_status[1:0]
//   cfg      in   cfg_we (no wait)   cfg_wdata[7:0] = slave address
//
// One request per cycle sustained while out_if is not stalled; a request is written into the queue
// at the edge that accepts it, and its frame byte, if any, then goes from the queue head into the output register.
// The two-entry queue lets the front keep accepting while out_if is stalled.
// Reset (rst_n low, synchronous) disarms, empties the queue, address = 1.
`default_nettype none

module modbus_response_framer_top
  import mrf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  mrf_in_if.sink          in_if,
  mrf_out_if.source       out_if
);

  queue_head_t head;
  logic        pop;

  mrf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .head      (head),
    .pop       (pop)
  );

  mrf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule

`default_nettype wire

@@ sv/mrf_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
// Holds the slave address register. Depends on mrf_pkg and mrf_ifs.
`default_nettype none

module mrf_front
  import mrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  mrf_in_if.sink           in_if,
  output queue_head_t      head,
  input  wire logic        pop
);

  logic [7:0]        slave_addr_r;
  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  item_t             cls;
  logic              push;

  always_comb begin
    cls.is_arm   = in_if.mode;
    cls.addr_hit = (in_if.rx_byte == slave_addr_r);
    cls.rx_byte  = in_if.rx_byte;
    if ((in_if.rx_byte & FC_EXC_BIT_MASK) != 8'h00) begin
      cls.fc_class = FC_EXCEPTION;
    end else if (in_if.rx_byte == FC_READ_HOLDING) begin
      cls.fc_class = FC_READ;
    end else if (in_if.rx_byte == FC_WRITE_SINGLE) begin
      cls.fc_class = FC_WRITE;
    end else begin
      cls.fc_class = FC_OTHER;
    end
  end

  assign in_if.ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign head.valid  = (cnt_r != '0);
  assign head.item   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= SLAVE_ADDR_RESET;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        slave_addr_r <= cfg_wdata;
      end
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

@@ sv/mrf_back.sv @@
// Back end: frame state machine, CRC check and output register.
// Consumes classified requests from mrf_front. Depends on mrf_pkg and mrf_ifs.
`default_nettype none

module mrf_back
  import mrf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  queue_head_t head,
  output logic        pop,
  mrf_out_if.source   out_if
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_FUNC,
    PH_COUNT,
    PH_BODY,
    PH_STALL
  } phase_t;

  phase_t      phase_r, phase_nxt, ph;
  logic        armed_r, armed_nxt;
  logic [8:0]  cnt_r, cnt_nxt, cnt_base, cnt_inc;
  logic [8:0]  exp_r, exp_nxt;
  logic [15:0] crc_r, crc_nxt, crc_base, crc_new;
  logic        take;
  logic        res_valid, res_last;
  status_t     res_status;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic [8:0]  out_idx_r;
  logic        out_last_r;
  status_t     out_status_r;

  item_t it;
  assign it  = head.item;
  assign pop = head.valid && (!out_valid_r || out_if.ready);

  always_comb begin
    phase_nxt  = phase_r;
    armed_nxt  = armed_r;
    cnt_nxt    = cnt_r;
    exp_nxt    = exp_r;
    crc_nxt    = crc_r;
    res_valid  = 1'b0;
    res_last   = 1'b0;
    res_status = ST_PROGRESS;
    take       = 1'b0;
    ph         = phase_r;
    cnt_base   = cnt_r;
    crc_base   = crc_r;
    if (phase_r == PH_HUNT) begin
      ph       = PH_FUNC;
      cnt_base = '0;
      crc_base = CRC_INIT;
    end
    crc_new = crc16_byte(crc_base, it.rx_byte);
    cnt_inc = cnt_base + 9'd1;

    if (pop) begin
      if (it.is_arm) begin
        armed_nxt = 1'b1;
        phase_nxt = PH_HUNT;
        cnt_nxt   = '0;
        exp_nxt   = '0;
        crc_nxt   = CRC_INIT;
      end else if (armed_r && phase_r != PH_STALL) begin
        take = (phase_r != PH_HUNT) || it.addr_hit;
      end
    end

    if (take) begin
      res_valid = 1'b1;
      crc_nxt   = crc_new;
      cnt_nxt   = cnt_inc;
      phase_nxt = ph;
      if (cnt_base != '0) begin
        unique case (ph)
          PH_FUNC: begin
            unique case (it.fc_class)
              FC_EXCEPTION: begin
                exp_nxt   = LEN_EXCEPTION;
                phase_nxt = PH_BODY;
              end
              FC_READ:  phase_nxt = PH_COUNT;
              FC_WRITE: begin
                exp_nxt   = LEN_WRITE_ECHO;
                phase_nxt = PH_BODY;
              end
              default: begin
                res_last   = 1'b1;
                res_status = ST_UNKNOWN;
                phase_nxt  = PH_STALL;
              end
            endcase
          end
          PH_COUNT: begin
            exp_nxt   = {1'b0, it.rx_byte} + LEN_READ_EXTRA;
            phase_nxt = PH_BODY;
          end
          PH_BODY: begin
            if (cnt_inc >= exp_r) begin
              res_last = 1'b1;
              if (crc_new == 16'h0000) begin
                res_status = ST_GOOD;
                armed_nxt  = 1'b0;
              end else begin
                res_status = ST_BAD;
              end
              phase_nxt = PH_HUNT;
              cnt_nxt   = '0;
              exp_nxt   = '0;
              crc_nxt   = CRC_INIT;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid_nxt = res_valid || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      armed_r     <= 1'b0;
      cnt_r       <= '0;
      exp_r       <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      armed_r     <= armed_nxt;
      cnt_r       <= cnt_nxt;
      exp_r       <= exp_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid) begin
      out_byte_r   <= it.rx_byte;
      out_idx_r    <= cnt_base;
      out_last_r   <= res_last;
      out_status_r <= res_status;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.frame_byte   = out_byte_r;
  assign out_if.byte_index   = out_idx_r;
  assign out_if.frame_last   = out_last_r;
  assign out_if.frame_status = out_status_r;

  // Stall phase is only entered while armed and left only by an arm request.
  a_stall_armed: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STALL |-> armed_r)
    else $error("stall phase while disarmed");

  // Only the final byte of a frame carries a verdict.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_status_r != ST_PROGRESS)))
    else $error("status and last flag disagree");

  // A good frame disarms the block.
  a_good_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_status == ST_GOOD |=> !armed_r && phase_r == PH_HUNT)
    else $error("good frame did not disarm");

endmodule

`default_nettype wire
